// File: design/max_heap_priority_queue_unit_macros.svh
// Assertion helpers shared by the queue RTL.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef MAX_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH

// A property that must hold on every clock edge.
`define MHPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An antecedent that must be followed by a consequent in the next cycle.
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mhpq_pkg.sv
package mhpq_pkg;

    // Number of heap slots; slots are numbered 1..CAPACITY.
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // One stored heap entry.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] y;
        logic [KEY_W-1:0] x;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Heap slot number (1-based) to memory address.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [CNT_W-1:0] slot);
        logic [CNT_W-1:0] idx;
        idx = slot - CNT_W'(1);
        return idx[ADDR_W-1:0];
    endfunction

endpackage

// File: design/max_heap_priority_queue_unit.sv
// Binary max-heap priority queue of signed 32-bit keys, each carrying a
// two-word payload (entry_x, entry_y).
//
// Usage: a request transfer happens at a rising edge where start is high
// and busy is low. req_type selects insert, pop of the maximum, or clear.
// Every request produces exactly one result, shown for one cycle with done
// high: the top entry (zero when empty), entry_count, is_empty and status.
// The receiver cannot stall; a result must be taken in the cycle it shows.
//
// Sequence: an insert climbs from the new last slot, at most log2 of the
// capacity levels, reading the parent and making one comparator decision per
// level. A pop moves the last entry to the root and sinks it: each level
// reads the left child, then the right child if there is one, through the
// single read port of the heap memory, and makes up to two decisions on the
// one key comparator; a pop of the only entry does no sift. Clear, refused
// requests and the unused code go straight to the result. One request is
// worked on at a time; busy drops in the cycle the result is shown.
//
// Reset empties the heap at once (the fill count is cleared); no sweep of
// the memory is needed because only slots up to the fill count are read.
module max_heap_priority_queue_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   req_type,
    input  logic signed [31:0]           entry_key,
    input  logic signed [31:0]           entry_x,
    input  logic signed [31:0]           entry_y,
    output logic                         done,
    output logic signed [31:0]           top_key,
    output logic signed [31:0]           top_x,
    output logic signed [31:0]           top_y,
    output logic [mhpq_pkg::CNT_W-1:0]   entry_count,
    output logic                         is_empty,
    output logic [1:0]                   status
);

`include "max_heap_priority_queue_unit_macros.svh"

    localparam int CNT_W  = mhpq_pkg::CNT_W;
    localparam int ADDR_W = mhpq_pkg::ADDR_W;
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(mhpq_pkg::CAPACITY);
    localparam logic [CNT_W-1:0] SLOT_ONE = CNT_W'(1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP_CHECK = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_POP_LAST = 4'd3;
    localparam logic [3:0] S_DN_CHECK = 4'd4;
    localparam logic [3:0] S_DN_LEFT  = 4'd5;
    localparam logic [3:0] S_DN_RIGHT = 4'd6;
    localparam logic [3:0] S_DN_DEC   = 4'd7;
    localparam logic [3:0] S_REPORT   = 4'd8;

    logic [3:0]              state_reg,  state_next;
    logic [CNT_W-1:0]        count_reg,  count_next;
    logic [CNT_W-1:0]        pos_reg,    pos_next;
    logic [CNT_W-1:0]        cidx_reg,   cidx_next;
    logic [1:0]              status_reg, status_next;
    mhpq_pkg::entry_t        cur_reg,    cur_next;
    mhpq_pkg::entry_t        child_reg,  child_next;
    mhpq_pkg::entry_t        root_reg;

    logic                    done_reg,     done_next;
    mhpq_pkg::entry_t        top_reg,      top_next;
    logic [CNT_W-1:0]        cnt_out_reg,  cnt_out_next;
    logic                    empty_reg,    empty_next;
    logic [1:0]              st_out_reg,   st_out_next;

    // Heap memory ports.
    logic                    wr_en;
    logic [CNT_W-1:0]        wr_slot;
    mhpq_pkg::entry_t        wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    mhpq_pkg::entry_t        rd_data;

    // The one key comparator, shared by every decision of both sifts.
    logic [31:0]             cmp_a;
    logic [31:0]             cmp_b;
    logic                    cmp_gt;

    // Left child slot of the current position; one bit wider so that
    // children past the last slot are still seen as such.
    logic [CNT_W:0]          child_slot;

    mhpq_ram #(
        .DATA_W (mhpq_pkg::ENTRY_W),
        .DEPTH  (mhpq_pkg::CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (mhpq_pkg::slot_addr(wr_slot)),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign child_slot = {pos_reg, 1'b0};

    always_comb
    begin
        case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = cur_reg.key;
                cmp_b = rd_data.key;
            end
            S_DN_RIGHT:
            begin
                cmp_a = rd_data.key;
                cmp_b = child_reg.key;
            end
            S_DN_DEC:
            begin
                cmp_a = child_reg.key;
                cmp_b = cur_reg.key;
            end
            default:
            begin
                cmp_a = cur_reg.key;
                cmp_b = rd_data.key;
            end
        endcase
    end

    assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        cidx_next    = cidx_reg;
        status_next  = status_reg;
        cur_next     = cur_reg;
        child_next   = child_reg;
        done_next    = 1'b0;
        top_next     = top_reg;
        cnt_out_next = cnt_out_reg;
        empty_next   = empty_reg;
        st_out_next  = st_out_reg;
        wr_en        = 1'b0;
        wr_slot      = pos_reg;
        wr_data      = cur_reg;
        rd_en        = 1'b0;
        rd_addr      = mhpq_pkg::slot_addr(pos_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = mhpq_pkg::ST_OK;
                    state_next  = S_REPORT;
                    case (req_type)
                        mhpq_pkg::REQ_INSERT:
                        begin
                            if (count_reg == CAP_CNT)
                            begin
                                status_next = mhpq_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + SLOT_ONE;
                                pos_next   = count_reg + SLOT_ONE;
                                cur_next   = '{key: entry_key, y: entry_y, x: entry_x};
                                state_next = S_UP_CHECK;
                            end
                        end
                        mhpq_pkg::REQ_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = mhpq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = mhpq_pkg::slot_addr(count_reg);
                                state_next = S_POP_LAST;
                            end
                        end
                        mhpq_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = S_REPORT;
                        end
                    endcase
                end
            end

            S_UP_CHECK:
            begin
                if (pos_reg == SLOT_ONE)
                begin
                    wr_en      = 1'b1;
                    state_next = S_REPORT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mhpq_pkg::slot_addr(pos_reg >> 1);
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (cmp_gt)
                begin
                    // Parent moves down into the hole.
                    wr_data    = rd_data;
                    pos_next   = pos_reg >> 1;
                    state_next = S_UP_CHECK;
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end

            S_POP_LAST:
            begin
                cur_next   = rd_data;
                count_next = count_reg - SLOT_ONE;
                pos_next   = SLOT_ONE;
                if (count_reg == SLOT_ONE)
                begin
                    state_next = S_REPORT;
                end
                else
                begin
                    state_next = S_DN_CHECK;
                end
            end

            S_DN_CHECK:
            begin
                if (child_slot > {1'b0, count_reg})
                begin
                    wr_en      = 1'b1;
                    state_next = S_REPORT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mhpq_pkg::slot_addr(child_slot[CNT_W-1:0]);
                    state_next = S_DN_LEFT;
                end
            end

            S_DN_LEFT:
            begin
                child_next = rd_data;
                cidx_next  = child_slot[CNT_W-1:0];
                if (child_slot < {1'b0, count_reg})
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mhpq_pkg::slot_addr(child_slot[CNT_W-1:0] + SLOT_ONE);
                    state_next = S_DN_RIGHT;
                end
                else
                begin
                    state_next = S_DN_DEC;
                end
            end

            S_DN_RIGHT:
            begin
                // The right child wins only when strictly greater.
                if (cmp_gt)
                begin
                    child_next = rd_data;
                    cidx_next  = cidx_reg + SLOT_ONE;
                end
                state_next = S_DN_DEC;
            end

            S_DN_DEC:
            begin
                wr_en = 1'b1;
                if (cmp_gt)
                begin
                    wr_data    = child_reg;
                    pos_next   = cidx_reg;
                    state_next = S_DN_CHECK;
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end

            S_REPORT:
            begin
                done_next    = 1'b1;
                top_next     = (count_reg != '0) ? root_reg : '0;
                cnt_out_next = count_reg;
                empty_next   = (count_reg == '0);
                st_out_next  = status_reg;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            status_reg  <= mhpq_pkg::ST_OK;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        cidx_reg    <= cidx_next;
        cur_reg     <= cur_next;
        child_reg   <= child_next;
        top_reg     <= top_next;
        cnt_out_reg <= cnt_out_next;
        empty_reg   <= empty_next;
        st_out_reg  <= st_out_next;
        // Shadow copy of slot 1 so the top entry never costs a memory read.
        if (wr_en && (wr_slot == SLOT_ONE))
        begin
            root_reg <= wr_data;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign top_key     = top_reg.key;
    assign top_x       = top_reg.x;
    assign top_y       = top_reg.y;
    assign entry_count = cnt_out_reg;
    assign is_empty    = empty_reg;
    assign status      = st_out_reg;

    `MHPQ_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy,
        "accepted request did not make the unit busy")
    `MHPQ_ASSERT_NEXT(a_single_strobe, done, !done,
        "result strobe held for more than one cycle")
    `MHPQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CAP_CNT,
        "fill count above capacity")
    `MHPQ_ASSERT_ALWAYS(a_full_status, !done || (status != mhpq_pkg::ST_FULL) ||
        (entry_count == CAP_CNT), "insert refused while heap not full")
    `MHPQ_ASSERT_ALWAYS(a_empty_flag, !done || (is_empty == (entry_count == '0)),
        "empty flag disagrees with entry count")

endmodule

// File: design/mhpq_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module mhpq_ram #(
    parameter int DATA_W = 96,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: tb/sv/heap_queue_checker.sv
`timescale 1ns / 1ps

module heap_queue_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [1:0]                    req_type,
    input  logic signed [31:0]            entry_key,
    input  logic signed [31:0]            entry_x,
    input  logic signed [31:0]            entry_y,
    input  logic                          done,
    input  logic signed [31:0]            top_key,
    input  logic signed [31:0]            top_x,
    input  logic signed [31:0]            top_y,
    input  logic [mhpq_pkg::CNT_W-1:0]    entry_count,
    input  logic                          is_empty,
    input  logic [1:0]                    status,
    output int                            outstanding,
    output int                            error_count
);

    typedef struct {
        logic signed [31:0]             key;
        logic signed [31:0]             x;
        logic signed [31:0]             y;
        logic [mhpq_pkg::CNT_W-1:0]     count;
        logic                           empty;
        logic [1:0]                     status;
    } heap_report_t;

    // Shadow copy of the heap, slots 1..CAPACITY.
    logic signed [mhpq_pkg::KEY_W-1:0] heap_key [1:mhpq_pkg::CAPACITY];
    logic signed [31:0]                heap_x   [1:mhpq_pkg::CAPACITY];
    logic signed [31:0]                heap_y   [1:mhpq_pkg::CAPACITY];
    int unsigned                       heap_fill = 0;

    heap_report_t expected_tops [$];
    int errors_seen  = 0;
    int result_index = 0;
    int owed         = 0;

    assign outstanding = owed;
    assign error_count = errors_seen;

    function automatic void sift_up_from(input int unsigned slot);
        logic signed [31:0] k;
        logic signed [31:0] px;
        logic signed [31:0] py;
        int unsigned        parent;
        k  = heap_key[slot];
        px = heap_x[slot];
        py = heap_y[slot];
        while (slot > 1)
        begin
            parent = slot >> 1;
            // An equal key stays below its parent.
            if (!(k > heap_key[parent]))
                break;
            heap_key[slot] = heap_key[parent];
            heap_x[slot]   = heap_x[parent];
            heap_y[slot]   = heap_y[parent];
            slot = parent;
        end
        heap_key[slot] = k;
        heap_x[slot]   = px;
        heap_y[slot]   = py;
    endfunction

    function automatic void sift_down_from(input int unsigned slot);
        logic signed [31:0] k;
        logic signed [31:0] px;
        logic signed [31:0] py;
        int unsigned        child;
        k  = heap_key[slot];
        px = heap_x[slot];
        py = heap_y[slot];
        while (1'b1)
        begin
            child = slot * 2;
            if (child > heap_fill)
                break;
            // The left child wins a tie.
            if (child < heap_fill && heap_key[child + 1] > heap_key[child])
                child = child + 1;
            if (!(heap_key[child] > k))
                break;
            heap_key[slot] = heap_key[child];
            heap_x[slot]   = heap_x[child];
            heap_y[slot]   = heap_y[child];
            slot = child;
        end
        heap_key[slot] = k;
        heap_x[slot]   = px;
        heap_y[slot]   = py;
    endfunction

    function automatic heap_report_t apply_request(
        input logic [1:0]         req,
        input logic signed [31:0] k,
        input logic signed [31:0] px,
        input logic signed [31:0] py
    );
        heap_report_t rep;
        rep.status = mhpq_pkg::ST_OK;
        case (req)
            mhpq_pkg::REQ_INSERT:
            begin
                if (heap_fill >= mhpq_pkg::CAPACITY)
                begin
                    rep.status = mhpq_pkg::ST_FULL;
                end
                else
                begin
                    heap_fill = heap_fill + 1;
                    heap_key[heap_fill] = k;
                    heap_x[heap_fill]   = px;
                    heap_y[heap_fill]   = py;
                    sift_up_from(heap_fill);
                end
            end
            mhpq_pkg::REQ_POP:
            begin
                if (heap_fill == 0)
                begin
                    rep.status = mhpq_pkg::ST_EMPTY;
                end
                else
                begin
                    heap_key[1] = heap_key[heap_fill];
                    heap_x[1]   = heap_x[heap_fill];
                    heap_y[1]   = heap_y[heap_fill];
                    heap_fill = heap_fill - 1;
                    if (heap_fill > 0)
                        sift_down_from(1);
                end
            end
            mhpq_pkg::REQ_CLEAR:
            begin
                heap_fill = 0;
            end
            default:
            begin
            end
        endcase
        if (heap_fill > 0)
        begin
            rep.key = heap_key[1];
            rep.x   = heap_x[1];
            rep.y   = heap_y[1];
        end
        else
        begin
            rep.key = '0;
            rep.x   = '0;
            rep.y   = '0;
        end
        rep.count = mhpq_pkg::CNT_W'(heap_fill);
        rep.empty = (heap_fill == 0);
        return rep;
    endfunction

    task automatic report_mismatch(input string what);
        errors_seen = errors_seen + 1;
        $display("MISMATCH at result %0d: %s", result_index, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %h, should be %h", name, got, want));
    endtask

    always @(posedge clk)
    begin : watch
        heap_report_t want;
        if (!rst_n)
        begin
            heap_fill = 0;
        end
        else
        begin
            // The result leaving at this edge belongs to an older transfer, so it is
            // checked before a transfer taken at the same edge is predicted.
            if (done)
            begin
                if (expected_tops.size() == 0)
                begin
                    report_mismatch("result with no request waiting");
                end
                else
                begin
                    want = expected_tops.pop_front();
                    check_field("top_key", top_key, want.key);
                    check_field("top_x", top_x, want.x);
                    check_field("top_y", top_y, want.y);
                    check_field("entry_count", entry_count, want.count);
                    check_field("is_empty", is_empty, want.empty);
                    check_field("status", status, want.status);
                end
                result_index = result_index + 1;
            end
            if (start && !busy)
                expected_tops.push_back(apply_request(req_type, entry_key, entry_x, entry_y));
        end
        owed <= expected_tops.size();
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // The block ignores this request code; it still answers with one result.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // A pop that sifts down through every level finishes well within this
    // tail, so it comfortably covers any result still in flight.
    localparam int TAIL_CYCLES = 64;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          start     = 1'b0;
    logic [1:0]                    req_type  = mhpq_pkg::REQ_INSERT;
    logic signed [31:0]            entry_key = '0;
    logic signed [31:0]            entry_x   = '0;
    logic signed [31:0]            entry_y   = '0;
    logic                          busy;
    logic                          done;
    logic signed [31:0]            top_key;
    logic signed [31:0]            top_x;
    logic signed [31:0]            top_y;
    logic [mhpq_pkg::CNT_W-1:0]    entry_count;
    logic                          is_empty;
    logic [1:0]                    status;
    int                            outstanding;
    int                            error_count;

    // Free-running 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    max_heap_priority_queue_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .entry_key   (entry_key),
        .entry_x     (entry_x),
        .entry_y     (entry_y),
        .done        (done),
        .top_key     (top_key),
        .top_x       (top_x),
        .top_y       (top_y),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .status      (status)
    );

    // The checker sees every transfer and every result; it keeps the count of
    // results still owed and the count of mismatches for the verdict here.
    heap_queue_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .entry_key   (entry_key),
        .entry_x     (entry_x),
        .entry_y     (entry_y),
        .done        (done),
        .top_key     (top_key),
        .top_x       (top_x),
        .top_y       (top_y),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .status      (status),
        .outstanding (outstanding),
        .error_count (error_count)
    );

    // Idle cycles before the next request. With idling off the requests go
    // back to back, so start stays high across several transfers.
    function automatic int pick_gap(input bit idle);
        if (!idle)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    // Keys lean toward narrow bands around zero and both extremes so that equal
    // keys are common; the ties exercise both the sift-up and the sift-down rules.
    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return 32'($urandom_range(0, 15)) - 32'd8;
            7:          return 32'h7FFF_FFF0 + 32'($urandom_range(0, 15));
            8:          return 32'h8000_0000 + 32'($urandom_range(0, 15));
            default:    return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // Payload words are mostly random, with the corner values mixed in.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Present one request and hold it until the block takes it. Start is
    // lowered only when a gap follows, so a back-to-back request never sees
    // start dropped and raised in the same time step. The task returns at
    // the edge at which the transfer happened.
    task automatic send_request(input logic [1:0] req, input logic [31:0] k,
                                input logic [31:0] px, input logic [31:0] py,
                                input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        req_type  <= req;
        entry_key <= k;
        entry_x   <= px;
        entry_y   <= py;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    // Stop sending and wait until every result owed has come back. The first
    // edge is taken before polling because the checker publishes its count
    // through a register.
    task automatic wait_for_results();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    // A stretch of random requests. insert_pct sets how often an insert is
    // chosen; the rest is mostly pops with a few clears and unused codes.
    task automatic run_mix(input int count, input int insert_pct, input bit idle);
        int         n;
        int         pick;
        logic [1:0] req;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < insert_pct)
                req = mhpq_pkg::REQ_INSERT;
            else if (pick < 96)
                req = mhpq_pkg::REQ_POP;
            else if (pick < 98)
                req = mhpq_pkg::REQ_CLEAR;
            else
                req = REQ_UNUSED;
            send_request(req, rand_key(), rand_word(), rand_word(), pick_gap(idle));
        end
    endtask

    initial
    begin : stimulus
        int n;

        // Reset is held low from time zero and released on a rising edge.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A pop from an empty heap must be refused.
        send_request(mhpq_pkg::REQ_POP, rand_word(), rand_word(), rand_word(), pick_gap(1));
        // Key extremes, with payload extremes, and a zero key.
        send_request(mhpq_pkg::REQ_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                     pick_gap(1));
        send_request(mhpq_pkg::REQ_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                     pick_gap(1));
        send_request(mhpq_pkg::REQ_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                     pick_gap(1));
        // An equal maximum key must not displace the current top.
        send_request(mhpq_pkg::REQ_INSERT, 32'h7FFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0,
                     pick_gap(1));
        send_request(mhpq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                     pick_gap(1));
        // Two equal keys side by side; the sift-down must take the left one.
        send_request(mhpq_pkg::REQ_INSERT, 32'h0000_0001, 32'h0000_0011, 32'h0000_0022,
                     pick_gap(1));
        send_request(mhpq_pkg::REQ_INSERT, 32'h0000_0001, 32'h0000_0033, 32'h0000_0044,
                     pick_gap(1));
        send_request(mhpq_pkg::REQ_POP, rand_word(), rand_word(), rand_word(), pick_gap(1));
        send_request(mhpq_pkg::REQ_POP, rand_word(), rand_word(), rand_word(), pick_gap(1));
        send_request(mhpq_pkg::REQ_POP, rand_word(), rand_word(), rand_word(), pick_gap(1));
        // The unused code leaves the heap as it is.
        send_request(REQ_UNUSED, rand_word(), rand_word(), rand_word(), pick_gap(1));
        // Clear with entries held, then a refused pop on the cleared heap.
        send_request(mhpq_pkg::REQ_CLEAR, rand_word(), rand_word(), rand_word(), pick_gap(1));
        send_request(mhpq_pkg::REQ_POP, rand_word(), rand_word(), rand_word(), pick_gap(1));
        // A heap of one entry popped back to empty.
        send_request(mhpq_pkg::REQ_INSERT, 32'h0000_0005, 32'hDEAD_BEEF, 32'hCAFE_F00D,
                     pick_gap(1));
        send_request(mhpq_pkg::REQ_POP, rand_word(), rand_word(), rand_word(), pick_gap(1));
        // Clear and the unused code on an empty heap.
        send_request(mhpq_pkg::REQ_CLEAR, rand_word(), rand_word(), rand_word(), pick_gap(1));
        send_request(REQ_UNUSED, rand_word(), rand_word(), rand_word(), pick_gap(1));

        // The sender holds off here until every result is back.
        wait_for_results();

        // Random part: a small heap that empties often, then a burst with no
        // idling at all.
        run_mix(80, 55, 1'b1);
        run_mix(40, 70, 1'b0);
        wait_for_results();

        // Fill the heap to capacity from empty and push a few more inserts,
        // which must be refused as full. The first 500 go back to back.
        send_request(mhpq_pkg::REQ_CLEAR, rand_word(), rand_word(), rand_word(), pick_gap(1));
        for (n = 0; n < mhpq_pkg::CAPACITY + 3; n++)
        begin
            send_request(mhpq_pkg::REQ_INSERT, rand_key(), rand_word(), rand_word(),
                         pick_gap(n >= 500));
        end

        // Deep sift-downs from a full heap, then a clear of a large heap and a
        // final mixed stretch.
        run_mix(60, 35, 1'b1);
        send_request(mhpq_pkg::REQ_CLEAR, rand_word(), rand_word(), rand_word(), pick_gap(1));
        run_mix(20, 55, 1'b1);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit: the slowest correct run is under a millisecond.
    initial
    begin : watchdog
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
